// ----- hdl/hnf_pkg.sv -----
// Package for the hex number formatter: transfer payload types, ASCII codes
// and the digit lookup. No dependencies.
`default_nettype none
package hnf_pkg;

    localparam int VALUE_W = 32;
    localparam int CNT_W   = 7;
    localparam int NDIG_W  = 4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    typedef struct packed {
        logic [31:0] value;
        logic        upper_case;
        logic        alt_prefix;
        logic        left_align;
        logic        zero_pad;
        logic [6:0]  field_width;
        logic [5:0]  min_digits;
    } t_hnf_in;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_char;
    } t_hnf_out;

    // control from the sequencer to the nibble shifter
    typedef struct packed {
        logic load;
        logic step;
    } t_shift_ctl;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? CH_A_UP : CH_A_LO;
        if (nib < 4'd10) begin
            hex_char = CH_ZERO + {4'b0, nib};
        end else begin
            hex_char = base + {4'b0, nib} - 8'd10;
        end
    endfunction

endpackage
`default_nettype wire

// ----- hdl/hnf_nib_shift.sv -----
// Nibble shifter: counts significant nibbles, aligns the leading digit to the
// top and shifts one nibble per digit. Depends on hnf_pkg.
`default_nettype none
module hnf_nib_shift (
    input  wire logic                 i_clk,
    input  wire logic [31:0]          i_value,
    input  wire hnf_pkg::t_shift_ctl  i_ctl,
    output logic [3:0]                o_ndig,
    output logic [3:0]                o_nib
);
    import hnf_pkg::*;

    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] n_val;
    logic [2:0]         lead;
    logic [4:0]         shamt;

    always_comb begin
        o_ndig = 4'd1;
        for (int i = 1; i < 8; i++) begin
            if ((i_value >> (4 * i)) != '0) begin
                o_ndig = 4'(i + 1);
            end
        end
    end

    assign lead  = 3'(4'd8 - o_ndig);
    assign shamt = {lead, 2'b00};

    always_comb begin
        n_val = r_val;
        if (i_ctl.load) begin
            n_val = i_value << shamt;
        end else if (i_ctl.step) begin
            n_val = {r_val[VALUE_W-5:0], 4'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_nib = r_val[VALUE_W-1:VALUE_W-4];

endmodule
`default_nettype wire

// ----- hdl/hnf_seq.sv -----
// Character sequencer: works out pad, prefix, zero and digit counts for one
// item and steps through them one character per transfer. Depends on hnf_pkg.
`default_nettype none
module hnf_seq #(
    parameter int MAX_WIDTH     = 64,
    parameter int MAX_PRECISION = 62
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire hnf_pkg::t_hnf_in    i_item,
    input  wire logic [3:0]          i_ndig,
    input  wire logic [3:0]          i_nib,
    input  wire logic                i_slot_free,
    output logic                     o_busy,
    output logic                     o_emit,
    output hnf_pkg::t_hnf_out        o_char,
    output hnf_pkg::t_shift_ctl      o_shift
);
    import hnf_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LSP  = 3'd1;
    localparam logic [2:0] PH_PRE  = 3'd2;
    localparam logic [2:0] PH_ZERO = 3'd3;
    localparam logic [2:0] PH_DIG  = 3'd4;
    localparam logic [2:0] PH_RSP  = 3'd5;

    logic [2:0]        r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_pre, n_pre;
    logic [CNT_W-1:0]  r_zero, n_zero;
    logic [CNT_W-1:0]  r_rsp, n_rsp;
    logic [NDIG_W-1:0] r_ndig, n_ndig;
    logic              r_upper, n_upper;

    logic [CNT_W-1:0] w_sat;
    logic [5:0]       p_sat;
    logic [5:0]       dchars;
    logic [CNT_W-1:0] body;
    logic [CNT_W-1:0] pad;
    logic             s_pre;
    logic [CNT_W-1:0] s_lsp, s_zero, s_rsp;
    logic             last;

    // setup arithmetic for the item being accepted
    always_comb begin
        w_sat  = (i_item.field_width > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH)
                                                          : i_item.field_width;
        p_sat  = (i_item.min_digits > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION)
                                                         : i_item.min_digits;
        dchars = (p_sat > {2'b00, i_ndig}) ? p_sat : {2'b00, i_ndig};
        s_pre  = i_item.alt_prefix && (i_item.value != '0);
        body   = CNT_W'(dchars) + (s_pre ? CNT_W'(2) : CNT_W'(0));
        pad    = (w_sat > body) ? (w_sat - body) : '0;
        s_lsp  = (!i_item.left_align && !i_item.zero_pad) ? pad : '0;
        s_rsp  = i_item.left_align ? pad : '0;
        s_zero = ((!i_item.left_align && i_item.zero_pad) ? pad : CNT_W'(0))
               + CNT_W'(dchars - {2'b00, i_ndig});
    end

    assign o_busy = (r_phase != PH_IDLE);
    assign o_emit = o_busy && i_slot_free;
    assign last   = ((r_phase == PH_DIG) && (r_cnt == CNT_W'(1)) && (r_rsp == '0))
                 || ((r_phase == PH_RSP) && (r_cnt == CNT_W'(1)));

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_pre   = r_pre;
        n_zero  = r_zero;
        n_rsp   = r_rsp;
        n_ndig  = r_ndig;
        n_upper = r_upper;
        o_char.char_out  = CH_SPACE;
        o_char.last_char = last;
        o_shift.load = i_start;
        o_shift.step = 1'b0;

        if (i_start) begin
            n_pre   = s_pre;
            n_zero  = s_zero;
            n_rsp   = s_rsp;
            n_ndig  = i_ndig;
            n_upper = i_item.upper_case;
            if (s_lsp != '0) begin
                n_phase = PH_LSP;
                n_cnt   = s_lsp;
            end else if (s_pre) begin
                n_phase = PH_PRE;
                n_cnt   = CNT_W'(2);
            end else if (s_zero != '0) begin
                n_phase = PH_ZERO;
                n_cnt   = s_zero;
            end else begin
                n_phase = PH_DIG;
                n_cnt   = CNT_W'(i_ndig);
            end
        end

        unique case (r_phase)
            PH_LSP: begin
                o_char.char_out = CH_SPACE;
            end
            PH_PRE: begin
                o_char.char_out = (r_cnt == CNT_W'(2)) ? CH_ZERO
                                : (r_upper ? CH_X_UP : CH_X_LO);
            end
            PH_ZERO: begin
                o_char.char_out = CH_ZERO;
            end
            PH_DIG: begin
                o_char.char_out = hex_char(i_nib, r_upper);
            end
            PH_RSP: begin
                o_char.char_out = CH_SPACE;
            end
            default: begin
                o_char.char_out = CH_SPACE;
            end
        endcase

        if (o_emit) begin
            n_cnt = r_cnt - CNT_W'(1);
            if (r_phase == PH_DIG) begin
                o_shift.step = 1'b1;
            end
            if (r_cnt == CNT_W'(1)) begin
                unique case (r_phase)
                    PH_LSP: begin
                        if (r_pre) begin
                            n_phase = PH_PRE;
                            n_cnt   = CNT_W'(2);
                        end else if (r_zero != '0) begin
                            n_phase = PH_ZERO;
                            n_cnt   = r_zero;
                        end else begin
                            n_phase = PH_DIG;
                            n_cnt   = CNT_W'(r_ndig);
                        end
                    end
                    PH_PRE: begin
                        if (r_zero != '0) begin
                            n_phase = PH_ZERO;
                            n_cnt   = r_zero;
                        end else begin
                            n_phase = PH_DIG;
                            n_cnt   = CNT_W'(r_ndig);
                        end
                    end
                    PH_ZERO: begin
                        n_phase = PH_DIG;
                        n_cnt   = CNT_W'(r_ndig);
                    end
                    PH_DIG: begin
                        if (r_rsp != '0) begin
                            n_phase = PH_RSP;
                            n_cnt   = r_rsp;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_RSP: begin
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre   <= n_pre;
        r_zero  <= n_zero;
        r_rsp   <= n_rsp;
        r_ndig  <= n_ndig;
        r_upper <= n_upper;
    end

    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_cnt != '0))
        else $error("active phase with empty count");

    a_pre_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PRE) |-> ((r_cnt == CNT_W'(1)) || (r_cnt == CNT_W'(2))))
        else $error("prefix count out of range");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_phase != PH_IDLE))
        else $error("accepted item produced no characters");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && last) |=> (r_phase == PH_IDLE))
        else $error("sequencer still active after last character");

    a_dig_ndig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIG) |-> (r_cnt <= CNT_W'(r_ndig)))
        else $error("digit count exceeds significant nibbles");

endmodule
`default_nettype wire

// ----- hdl/hex_number_formatter_unit.sv -----
// Hex number formatter, top level: input transfer, output register and the
// sequencer/shifter pair. Depends on hnf_pkg, hnf_nib_shift, hnf_seq.
//
// Renders one 32-bit value as hexadecimal ASCII, printf style, with prefix,
// precision zeros and width padding, and sends it one character per output
// transfer with last_char set on the final one. An item of N characters
// (N = max(width, prefix + digits), 1 to 64) occupies the character
// sequencer until its final character is emitted into the output
// register; o_in_stall stays high while the sequencer is working. The
// output register lets the next item be taken while the final character
// still waits.
`default_nettype none
module hex_number_formatter_unit #(
    parameter int MAX_WIDTH     = 64,
    parameter int MAX_PRECISION = 62
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire hnf_pkg::t_hnf_in   i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output hnf_pkg::t_hnf_out       o_out_data
);
    import hnf_pkg::*;

    logic       start;
    logic       busy;
    logic       emit;
    logic       slot_free;
    logic [3:0] ndig;
    logic [3:0] nib;
    t_hnf_out   seq_char;
    t_shift_ctl shift_ctl;

    logic       r_out_valid;
    t_hnf_out   r_out_data;

    assign o_in_stall = busy;
    assign start      = i_in_valid && !busy;
    assign slot_free  = !r_out_valid || !i_out_stall;

    hnf_nib_shift u_shift (
        .i_clk   (i_clk),
        .i_value (i_in_data.value),
        .i_ctl   (shift_ctl),
        .o_ndig  (ndig),
        .o_nib   (nib)
    );

    hnf_seq #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_PRECISION (MAX_PRECISION)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_in_data),
        .i_ndig      (ndig),
        .i_nib       (nib),
        .i_slot_free (slot_free),
        .o_busy      (busy),
        .o_emit      (emit),
        .o_char      (seq_char),
        .o_shift     (shift_ctl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= seq_char;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// ----- bench/hnf_char_checker.sv -----
`timescale 1ns / 100ps
// Checker for hex_number_formatter_unit: watches both transfer channels, renders
// each accepted item into expected characters and compares every output transfer.
// Depends on hnf_pkg.
module hnf_char_checker #(
    parameter int MAX_WIDTH     = 64,
    parameter int MAX_PRECISION = 62
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  hnf_pkg::t_hnf_in   i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  hnf_pkg::t_hnf_out  i_out_data,
    output int                 o_mismatches,
    output int                 o_chars_pending
);
    import hnf_pkg::*;

    t_hnf_out expected_chars[$];
    int       mismatch_count = 0;
    int       pending_chars  = 0;

    assign o_mismatches    = mismatch_count;
    assign o_chars_pending = pending_chars;

    function automatic void render_hex(input t_hnf_in item);
        string       digit_set;
        int unsigned width;
        int unsigned prec;
        int unsigned ndig;
        int unsigned dchars;
        int unsigned prefix_len;
        int unsigned pad;
        logic [7:0]  line[$];
        digit_set = item.upper_case ? "0123456789ABCDEF" : "0123456789abcdef";
        width = (item.field_width > MAX_WIDTH) ? MAX_WIDTH : item.field_width;
        prec  = (item.min_digits > MAX_PRECISION) ? MAX_PRECISION : item.min_digits;
        ndig = 1;
        for (int i = 1; i < 8; i++) begin
            if ((item.value >> (4 * i)) != 0) ndig = i + 1;
        end
        dchars     = (prec > ndig) ? prec : ndig;
        prefix_len = (item.alt_prefix && item.value != 0) ? 2 : 0;
        pad = (width > prefix_len + dchars) ? width - prefix_len - dchars : 0;
        if (!item.left_align && !item.zero_pad) repeat (pad) line.push_back(CH_SPACE);
        if (prefix_len != 0) begin
            line.push_back(CH_ZERO);
            line.push_back(item.upper_case ? CH_X_UP : CH_X_LO);
        end
        // zero padding goes after the prefix
        if (!item.left_align && item.zero_pad) repeat (pad) line.push_back(CH_ZERO);
        repeat (dchars - ndig) line.push_back(CH_ZERO);
        for (int i = ndig; i > 0; i--) begin
            line.push_back(digit_set[item.value[4*i-1 -: 4]]);
        end
        if (item.left_align) repeat (pad) line.push_back(CH_SPACE);
        foreach (line[k]) begin
            expected_chars.push_back('{char_out: line[k], last_char: (k == line.size() - 1)});
        end
    endfunction

    always @(posedge i_clk) begin
        t_hnf_out want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) render_hex(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected transfer: char_out %h, last_char %b",
                           i_out_data.char_out, i_out_data.last_char);
                    mismatch_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_data.char_out !== want.char_out) begin
                        $error("char_out: expected %h, actual %h",
                               want.char_out, i_out_data.char_out);
                        mismatch_count++;
                    end
                    if (i_out_data.last_char !== want.last_char) begin
                        $error("last_char: expected %b, actual %b",
                               want.last_char, i_out_data.last_char);
                        mismatch_count++;
                    end
                end
            end
            pending_chars <= expected_chars.size();
        end
    end

endmodule

// ----- bench/hex_number_formatter_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for hex_number_formatter_unit: clock, reset, stimulus and verdict.
// Depends on hnf_pkg, hex_number_formatter_unit and hnf_char_checker.
module hex_number_formatter_unit_tb;
    import hnf_pkg::*;

    localparam int ITEMS_PER_PHASE = 120;
    localparam int TAIL_CYCLES     = 100;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      in_valid   = 1'b0;
    logic      in_stall;
    t_hnf_in   in_data    = '0;
    logic      out_valid;
    logic      out_stall  = 1'b0;
    t_hnf_out  out_data;
    int        mismatches;
    int        chars_pending;

    int unsigned send_gap_pct   = 18;
    int unsigned recv_stall_pct = 84;
    int unsigned phase_gap[3]   = '{18, 84, 0};
    int unsigned phase_stall[3] = '{84, 18, 0};

    hex_number_formatter_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    hnf_char_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_data      (out_data),
        .o_mismatches    (mismatches),
        .o_chars_pending (chars_pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic t_hnf_in make_item(logic [31:0] value, logic upper, logic alt,
                                          logic left, logic zpad, logic [6:0] width,
                                          logic [5:0] prec);
        t_hnf_in item;
        item.value       = value;
        item.upper_case  = upper;
        item.alt_prefix  = alt;
        item.left_align  = left;
        item.zero_pad    = zpad;
        item.field_width = width;
        item.min_digits  = prec;
        return item;
    endfunction

    task automatic send_item(input t_hnf_in item);
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // pending count is registered and lags the checker queue, so always step at least once
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (chars_pending != 0);
    endtask

    initial begin
        t_hnf_in item;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_item(make_item(32'h0000_0000, 0, 0, 0, 0, 7'd0,   6'd0));
        send_item(make_item(32'h0000_0000, 0, 1, 0, 0, 7'd0,   6'd0));
        send_item(make_item(32'h0000_0000, 0, 0, 0, 1, 7'd5,   6'd0));
        send_item(make_item(32'h0000_0000, 1, 1, 0, 0, 7'd0,   6'd5));
        send_item(make_item(32'hFFFF_FFFF, 1, 1, 0, 0, 7'd0,   6'd0));
        send_item(make_item(32'hDEAD_BEEF, 0, 1, 0, 0, 7'd0,   6'd0));
        send_item(make_item(32'h0123_4567, 0, 0, 0, 0, 7'd0,   6'd0));
        send_item(make_item(32'h89AB_CDEF, 1, 0, 0, 0, 7'd0,   6'd0));
        send_item(make_item(32'h8000_0000, 0, 0, 0, 0, 7'd12,  6'd0));
        send_item(make_item(32'h0000_000A, 0, 0, 0, 0, 7'd0,   6'd0));
        send_item(make_item(32'h0000_0010, 1, 0, 0, 0, 7'd0,   6'd0));
        send_item(make_item(32'h0000_0001, 0, 0, 0, 0, 7'd64,  6'd0));
        send_item(make_item(32'h0000_0001, 0, 0, 0, 1, 7'd127, 6'd0));
        send_item(make_item(32'h0000_0001, 0, 0, 1, 0, 7'd100, 6'd0));
        send_item(make_item(32'h0000_0ABC, 0, 1, 0, 1, 7'd12,  6'd0));
        send_item(make_item(32'h0000_0ABC, 1, 1, 1, 1, 7'd20,  6'd4));
        send_item(make_item(32'h0000_0005, 0, 0, 0, 0, 7'd0,   6'd62));
        send_item(make_item(32'h0000_0005, 1, 1, 0, 0, 7'd0,   6'd63));
        send_item(make_item(32'h0000_0005, 0, 1, 0, 1, 7'd64,  6'd62));
        send_item(make_item(32'h7FFF_FFFF, 0, 1, 1, 0, 7'd1,   6'd1));
        send_item(make_item(32'h0000_000F, 1, 0, 0, 1, 7'd64,  6'd63));
        send_item(make_item(32'h0000_0000, 0, 1, 1, 1, 7'd127, 6'd63));
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct   <= phase_gap[phase];
            recv_stall_pct <= phase_stall[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                item.value       = $urandom >> (4 * $urandom_range(8));
                item.upper_case  = 1'($urandom_range(1));
                item.alt_prefix  = 1'($urandom_range(1));
                item.left_align  = 1'($urandom_range(1));
                item.zero_pad    = 1'($urandom_range(1));
                item.field_width = 7'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                               : $urandom_range(16));
                item.min_digits  = 6'(($urandom_range(9) == 0) ? $urandom_range(63)
                                                               : $urandom_range(10));
                send_item(item);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && chars_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
